// ===== rtl/fpcp_pkg.sv =====
// Shared types and constants for the flash programmer command parser.
`timescale 1ns / 1ps

package fpcp_pkg;

   // Host command letters.
   localparam logic [7:0] CH_W = 8'h57;
   localparam logic [7:0] CH_R = 8'h52;
   localparam logic [7:0] CH_M = 8'h4D;
   localparam logic [7:0] CH_S = 8'h53;
   localparam logic [7:0] CH_Z = 8'h5A;
   localparam logic [7:0] CH_D = 8'h44;
   localparam logic [7:0] CH_A = 8'h41;
   localparam logic [7:0] CH_B = 8'h42;
   localparam logic [7:0] CH_V = 8'h56;

   // Job queue between the parser and the result expander.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [3:0] {
      CMD_FORWARD       = 4'd0,
      CMD_BEGIN_SESSION = 4'd1,
      CMD_RELEASE_RESET = 4'd2,
      CMD_CHIP_ERASE    = 4'd3,
      CMD_RELEASE_BUS   = 4'd4,
      CMD_BOOTLOADER    = 4'd5,
      CMD_VERSION       = 4'd6,
      CMD_ERASE_SECTORS = 4'd7,
      CMD_START_WRITE   = 4'd8,
      CMD_WRITE_BYTE    = 4'd9,
      CMD_NEXT_PAGE     = 4'd10,
      CMD_FINISH_WRITE  = 4'd11,
      CMD_READ_RANGE    = 4'd12
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ARG0 = 3'd1,
      PH_ARG1 = 3'd2,
      PH_ARG2 = 3'd3,
      PH_ARG3 = 3'd4,
      PH_DATA = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_W    = 3'd1,
      OP_R    = 3'd2,
      OP_M    = 3'd3,
      OP_S    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      SEL_MAIN   = 2'd0,
      SEL_PAGE   = 2'd1,
      SEL_FINISH = 2'd2
   } sel_type;

   // One parsed request: a main result plus optional next page and finish results.
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] address;
      logic [31:0] length;
      logic [7:0]  data;
      logic [31:0] address2;
      logic        page;
      logic        finish;
   } job_type;

endpackage

// ===== rtl/flash_programmer_command_parser.sv =====
// Top level of the flash programmer command parser.
`timescale 1ns / 1ps

// Host byte parser for a flash programmer. Each request carries one byte from
// the host. With programming mode clear the byte comes back as a forward result
// for the UART bridge; with it set the byte drives a command parser that emits
// board commands (begin session, release reset, chip erase, release bus,
// bootloader, version), erase ranges, read ranges and write sequences with
// start write, write byte, next page and finish write. One request is accepted
// every clock cycle while the job queue has room: the parser in the front end
// finishes each byte in the cycle it is taken and places at most one job into
// a four-entry job queue. The back end delivers one result per cycle from the
// head of that queue while the receiver pops, so a write byte that also crosses
// a page or ends the count yields two or three results; req_full rises only
// when the queue is full. The page offset of the base address is computed by a
// three-stage remainder pipeline that always finishes well before a start write
// can use it. PAGE_BYTES may be any page size from 16 to 4096 bytes. Programming
// mode should only be changed while no request is outstanding.
module flash_programmer_command_parser #(
   parameter int PAGE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_command,
   output logic [31:0] rsp_address,
   output logic [31:0] rsp_length,
   output logic [7:0]  rsp_data,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_programming_mode
);

   import fpcp_pkg::*;

   localparam int PW = $clog2(PAGE_BYTES);

   logic          accept;
   logic          queue_full;
   logic          queue_empty;
   logic          queue_pop;
   logic          job_valid;
   job_type       job;
   job_type       head_job;
   logic [31:0]   base_address;
   logic [PW-1:0] base_rem;

   // A request is taken whenever the job queue has room.
   assign accept   = req_push && !queue_full;
   assign req_full = queue_full;

   fpcp_page_mod #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_page_mod (
      .clock        (clock),
      .base_address (base_address),
      .base_rem     (base_rem)
   );

   fpcp_front #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_programming_mode (csr_programming_mode),
      .accept               (accept),
      .rx_byte              (req_rx_byte),
      .base_rem             (base_rem),
      .base_address         (base_address),
      .job_valid            (job_valid),
      .job                  (job)
   );

   fpcp_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_valid),
      .push_job (job),
      .pop      (queue_pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   fpcp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_command (rsp_command),
      .rsp_address (rsp_address),
      .rsp_length  (rsp_length),
      .rsp_data    (rsp_data),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== rtl/fpcp_page_mod.sv =====
// Pipelined remainder of the base address modulo the page size.
`timescale 1ns / 1ps

module fpcp_page_mod #(
   parameter int PAGE_BYTES = 256
) (
   input  logic                          clock,
   input  logic [31:0]                   base_address,
   output logic [$clog2(PAGE_BYTES)-1:0] base_rem
);

   localparam int PW    = $clog2(PAGE_BYTES);
   localparam int VW    = PW + 10;
   localparam int RW    = PW + 12;
   localparam int SHIFT = VW + PW;
   localparam int QW    = VW + RW - SHIFT;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
   localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];
   // Weights of the four address bytes modulo the page size.
   localparam int WT0 = 1 % PAGE_BYTES;
   localparam int WT1 = 256 % PAGE_BYTES;
   localparam int WT2 = (WT1 * 256) % PAGE_BYTES;
   localparam int WT3 = (WT2 * 256) % PAGE_BYTES;

   logic [VW-1:0]    v_ff, v_in, v2_ff;
   logic [QW-1:0]    q_ff, q_in;
   logic [PW-1:0]    rem_ff, rem_in;
   logic [VW+RW-1:0] prod;
   logic [VW-1:0]    qp;

   always_comb begin
      // Byte-weighted sum keeps the same residue and stays narrow.
      v_in = VW'(base_address[7:0])   * VW'(WT0)
           + VW'(base_address[15:8])  * VW'(WT1)
           + VW'(base_address[23:16]) * VW'(WT2)
           + VW'(base_address[31:24]) * VW'(WT3);
      // Reciprocal is exact for every sum this narrow.
      prod   = (VW+RW)'(v_ff) * (VW+RW)'(RECIP);
      q_in   = prod[VW+RW-1:SHIFT];
      qp     = VW'(q_ff) * VW'(PAGE_BYTES);
      rem_in = PW'(v2_ff - qp);
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      v2_ff  <= v_ff;
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign base_rem = rem_ff;

endmodule

// ===== rtl/fpcp_front.sv =====
// Front end: mode register, byte parser state and job generation.
`timescale 1ns / 1ps

module fpcp_front #(
   parameter int PAGE_BYTES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_programming_mode,
   input  logic                          accept,
   input  logic [7:0]                    rx_byte,
   input  logic [$clog2(PAGE_BYTES)-1:0] base_rem,
   output logic [31:0]                   base_address,
   output logic                          job_valid,
   output fpcp_pkg::job_type             job
);

   import fpcp_pkg::*;

   localparam int PW = $clog2(PAGE_BYTES);

   logic          mode_ff, mode_in;
   phase_type     phase_ff, phase_in;
   op_type        op_ff, op_in;
   logic [31:0]   base_ff, base_in;
   logic [31:0]   count_ff, count_in;
   logic [31:0]   ptr_ff, ptr_in;
   logic [15:0]   efirst_ff, efirst_in;
   logic [15:0]   elast_ff, elast_in;
   logic [PW-1:0] rem_ff, rem_in;
   logic [1:0]    lane;
   logic [31:0]   ptr_next;
   logic [31:0]   count_next;
   logic [PW-1:0] rem_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         phase_ff  <= PH_IDLE;
         op_ff     <= OP_NONE;
         base_ff   <= '0;
         count_ff  <= '0;
         ptr_ff    <= '0;
         efirst_ff <= '0;
         elast_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         phase_ff  <= phase_in;
         op_ff     <= op_in;
         base_ff   <= base_in;
         count_ff  <= count_in;
         ptr_ff    <= ptr_in;
         efirst_ff <= efirst_in;
         elast_ff  <= elast_in;
      end
   end

   // Page offset of the write pointer; loaded before any data byte uses it.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
   end

   always_comb begin
      mode_in   = csr_we ? csr_programming_mode : mode_ff;
      phase_in  = phase_ff;
      op_in     = op_ff;
      base_in   = base_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      efirst_in = efirst_ff;
      elast_in  = elast_ff;
      rem_in    = rem_ff;

      lane       = 2'(phase_ff - PH_ARG0);
      ptr_next   = ptr_ff + 32'd1;
      count_next = count_ff - 32'd1;
      // The pointer wrapping to zero always lands on a page start.
      rem_next   = (rem_ff == PW'(PAGE_BYTES - 1) || ptr_next == '0) ? '0 : rem_ff + PW'(1);

      job_valid    = 1'b0;
      job.cmd      = CMD_FORWARD;
      job.address  = '0;
      job.length   = '0;
      job.data     = '0;
      job.address2 = '0;
      job.page     = 1'b0;
      job.finish   = 1'b0;

      if (accept) begin
         if (!mode_ff) begin
            job_valid = 1'b1;
            job.data  = rx_byte;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  case (rx_byte)
                     CH_W, CH_R: begin
                        op_in     = (rx_byte == CH_W) ? OP_W : OP_R;
                        count_in  = '0;
                        phase_in  = PH_ARG0;
                        job_valid = 1'b1;
                        job.cmd   = CMD_BEGIN_SESSION;
                     end
                     CH_D: begin
                        job_valid = 1'b1;
                        job.cmd   = CMD_RELEASE_RESET;
                     end
                     CH_Z: begin
                        job_valid = 1'b1;
                        job.cmd   = CMD_CHIP_ERASE;
                     end
                     CH_A: begin
                        job_valid = 1'b1;
                        job.cmd   = CMD_RELEASE_BUS;
                     end
                     CH_B: begin
                        job_valid = 1'b1;
                        job.cmd   = CMD_BOOTLOADER;
                     end
                     CH_V: begin
                        job_valid = 1'b1;
                        job.cmd   = CMD_VERSION;
                     end
                     CH_M: begin
                        op_in    = OP_M;
                        base_in  = '0;
                        phase_in = PH_ARG0;
                     end
                     CH_S: begin
                        op_in     = OP_S;
                        efirst_in = '0;
                        elast_in  = '0;
                        phase_in  = PH_ARG0;
                     end
                     default: begin
                     end
                  endcase
               end
               PH_ARG0, PH_ARG1, PH_ARG2, PH_ARG3: begin
                  case (op_ff)
                     OP_M: begin
                        base_in[{lane, 3'b000} +: 8] = base_ff[{lane, 3'b000} +: 8] | rx_byte;
                        phase_in = (phase_ff == PH_ARG3) ? PH_IDLE : phase_type'(phase_ff + 3'd1);
                     end
                     OP_S: begin
                        if (!lane[1]) begin
                           efirst_in[{lane[0], 3'b000} +: 8] =
                              efirst_ff[{lane[0], 3'b000} +: 8] | rx_byte;
                        end else begin
                           elast_in[{lane[0], 3'b000} +: 8] =
                              elast_ff[{lane[0], 3'b000} +: 8] | rx_byte;
                        end
                        if (phase_ff == PH_ARG3) begin
                           phase_in    = PH_IDLE;
                           job_valid   = 1'b1;
                           job.cmd     = CMD_ERASE_SECTORS;
                           job.address = {16'd0, efirst_in};
                           job.length  = {16'd0, elast_in};
                        end else begin
                           phase_in = phase_type'(phase_ff + 3'd1);
                        end
                     end
                     OP_W, OP_R: begin
                        count_in[{lane, 3'b000} +: 8] = count_ff[{lane, 3'b000} +: 8] | rx_byte;
                        if (phase_ff != PH_ARG3) begin
                           phase_in = phase_type'(phase_ff + 3'd1);
                        end else if (op_ff == OP_W) begin
                           ptr_in      = base_ff;
                           rem_in      = base_rem;
                           phase_in    = PH_DATA;
                           job_valid   = 1'b1;
                           job.cmd     = CMD_START_WRITE;
                           job.address = base_ff;
                           job.length  = count_in;
                        end else begin
                           phase_in    = PH_IDLE;
                           job_valid   = 1'b1;
                           job.cmd     = CMD_READ_RANGE;
                           job.address = base_ff;
                           job.length  = count_in;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               PH_DATA: begin
                  if (op_ff == OP_W) begin
                     ptr_in       = ptr_next;
                     count_in     = count_next;
                     rem_in       = rem_next;
                     job_valid    = 1'b1;
                     job.cmd      = CMD_WRITE_BYTE;
                     job.address  = ptr_ff;
                     job.data     = rx_byte;
                     job.address2 = ptr_next;
                     job.page     = (rem_next == '0);
                     job.finish   = (count_next == '0);
                     if (count_next == '0) begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign base_address = base_ff;

endmodule

// ===== rtl/fpcp_job_queue.sv =====
// Short job queue between the parser and the result expander.
`timescale 1ns / 1ps

module fpcp_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fpcp_pkg::job_type push_job,
   input  logic              pop,
   output fpcp_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);

   import fpcp_pkg::*;

   job_type             mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in;
   logic [QUEUE_AW-1:0] rd_ff, rd_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   always_comb begin
      wr_in    = push ? wr_ff + QUEUE_AW'(1) : wr_ff;
      rd_in    = pop ? rd_ff + QUEUE_AW'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_job;
      end
   end

   assign head_job = mem[rd_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));

endmodule

// ===== rtl/fpcp_back.sv =====
// Back end: expands each queued job into one to three results.
`timescale 1ns / 1ps

module fpcp_back (
   input  logic              clock,
   input  logic              reset,
   input  fpcp_pkg::job_type head_job,
   input  logic              queue_empty,
   output logic              queue_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [3:0]        rsp_command,
   output logic [31:0]       rsp_address,
   output logic [31:0]       rsp_length,
   output logic [7:0]        rsp_data,
   output logic              rsp_last
);

   import fpcp_pkg::*;

   sel_type sel_ff, sel_in;
   cmd_type cmd;
   logic    fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= SEL_MAIN;
      end else begin
         sel_ff <= sel_in;
      end
   end

   always_comb begin
      cmd         = head_job.cmd;
      rsp_address = head_job.address;
      rsp_length  = head_job.length;
      rsp_data    = head_job.data;
      rsp_last    = !(head_job.page || head_job.finish);
      case (sel_ff)
         SEL_MAIN: begin
         end
         SEL_PAGE: begin
            cmd         = CMD_NEXT_PAGE;
            rsp_address = head_job.address2;
            rsp_length  = '0;
            rsp_data    = '0;
            rsp_last    = !head_job.finish;
         end
         SEL_FINISH: begin
            cmd         = CMD_FINISH_WRITE;
            rsp_address = head_job.address2;
            rsp_length  = '0;
            rsp_data    = '0;
            rsp_last    = 1'b1;
         end
         default: begin
         end
      endcase

      fire      = rsp_pop && !queue_empty;
      queue_pop = fire && rsp_last;
      sel_in    = sel_ff;
      if (fire) begin
         if (rsp_last) begin
            sel_in = SEL_MAIN;
         end else if (sel_ff == SEL_MAIN && head_job.page) begin
            sel_in = SEL_PAGE;
         end else begin
            sel_in = SEL_FINISH;
         end
      end
   end

   assign rsp_command = cmd;
   assign rsp_empty   = queue_empty;

endmodule

// ===== rtl/fpcp_checker.sv =====
// Port-level checks for the flash programmer command parser and their binding.
`timescale 1ns / 1ps

module fpcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [3:0]  rsp_command,
   input logic [31:0] rsp_address,
   input logic [31:0] rsp_length,
   input logic [7:0]  rsp_data,
   input logic        rsp_last
);

   import fpcp_pkg::*;

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // A waiting result holds until it is taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_command)
         && $stable(rsp_address) && $stable(rsp_length)
         && $stable(rsp_data) && $stable(rsp_last))
      else $error("waiting result changed before it was taken");

   // The rest of a request's results follows at once.
   a_followup: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !rsp_last |=> !rsp_empty)
      else $error("gap inside the results of one request");

   // Commands that always close the results of their request.
   a_closing: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_command == CMD_FINISH_WRITE || rsp_command == CMD_FORWARD
         || rsp_command == CMD_ERASE_SECTORS || rsp_command == CMD_READ_RANGE)
         |-> rsp_last)
      else $error("closing command without last");

endmodule

bind flash_programmer_command_parser fpcp_checker u_fpcp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_empty   (rsp_empty),
   .rsp_pop     (rsp_pop),
   .rsp_command (rsp_command),
   .rsp_address (rsp_address),
   .rsp_length  (rsp_length),
   .rsp_data    (rsp_data),
   .rsp_last    (rsp_last)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the flash programmer command parser.
`timescale 1ns / 1ps

module tb;
   import fpcp_pkg::*;

   // Page size used by both the block and the prediction below.
   localparam int          PAGE        = 256;
   localparam logic [31:0] PAGE_U      = PAGE;
   // Cycles without any accepted request or result before the run is declared hung.
   localparam int          STALL_LIMIT = 1000;
   // Cycles allowed for requests that produce no result to work through the block.
   localparam int          SETTLE_CYCLES = 16;
   // Length of the long receiver hold-off that fills the block up.
   localparam int          HOLD_CYCLES = 80;

   // One result as the parser should present it on the rsp_ side.
   typedef struct {
      cmd_type     command;
      logic [31:0] address;
      logic [31:0] length;
      logic [7:0]  data;
      logic        last;
   } parser_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [3:0]  rsp_command;
   logic [31:0] rsp_address;
   logic [31:0] rsp_length;
   logic [7:0]  rsp_data;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_programming_mode = 1'b0;

   // Host bytes waiting to be offered, and the results the parser still owes us.
   logic [7:0]        host_bytes[$];
   parser_result_type awaited_results[$];

   // Shadow copy of the parser: mode register plus the whole argument state.
   logic        mode_shadow = 1'b0;
   phase_type   cur_phase   = PH_IDLE;
   op_type      cur_op      = OP_NONE;
   logic [31:0] base_addr   = 32'd0;
   logic [31:0] byte_left   = 32'd0;
   logic [31:0] write_ptr   = 32'd0;
   logic [15:0] sector_lo   = 16'd0;
   logic [15:0] sector_hi   = 16'd0;

   int error_count  = 0;
   int stall_cycles = 0;
   int send_wait    = 0;
   int send_burst   = 0;
   int recv_wait    = 0;
   int recv_burst   = 0;
   int hold_left    = 0;
   bit hold_armed   = 1'b0;
   int queued_count = 0;
   // Base address that the stimulus generator last programmed, used to aim writes at pages.
   logic [31:0] gen_base = 32'd0;

   flash_programmer_command_parser #(
      .PAGE_BYTES(PAGE)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_rx_byte         (req_rx_byte),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_command         (rsp_command),
      .rsp_address         (rsp_address),
      .rsp_length          (rsp_length),
      .rsp_data            (rsp_data),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_programming_mode(csr_programming_mode)
   );

   // Free-running clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic parser_result_type make_result(cmd_type cmd, logic [31:0] addr,
                                                     logic [31:0] len, logic [7:0] dat);
      parser_result_type r;
      r.command = cmd;
      r.address = addr;
      r.length  = len;
      r.data    = dat;
      r.last    = 1'b0;
      return r;
   endfunction

   // Adds one result to the list of results the parser owes.
   task automatic owe_result(input cmd_type cmd, input logic [31:0] addr,
                             input logic [31:0] len, input logic [7:0] dat);
      awaited_results.push_back(make_result(cmd, addr, len, dat));
   endtask

   // Draws the idle gap for one handshake. Every so often a stretch of back-to-back
   // transfers is started so that the block also sees full rate on that side.
   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(20, 40);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   // Advances the shadow parser by one accepted host byte and records every result
   // that byte causes. The final result of a request carries the last flag.
   task automatic parse_host_byte(input logic [7:0] b);
      parser_result_type r;
      int                first_new;
      int                shift;
      first_new = awaited_results.size();
      shift = 0;
      if (!mode_shadow) begin
         // Bridge mode forwards the byte and leaves the parser exactly where it stood.
         owe_result(CMD_FORWARD, 32'd0, 32'd0, b);
      end else if (cur_phase == PH_IDLE) begin
         case (b)
            CH_W, CH_R: begin
               cur_op    = (b == CH_W) ? OP_W : OP_R;
               byte_left = 32'd0;
               cur_phase = PH_ARG0;
               owe_result(CMD_BEGIN_SESSION, 32'd0, 32'd0, 8'd0);
            end
            CH_D: owe_result(CMD_RELEASE_RESET, 32'd0, 32'd0, 8'd0);
            CH_Z: owe_result(CMD_CHIP_ERASE, 32'd0, 32'd0, 8'd0);
            CH_A: owe_result(CMD_RELEASE_BUS, 32'd0, 32'd0, 8'd0);
            CH_B: owe_result(CMD_BOOTLOADER, 32'd0, 32'd0, 8'd0);
            CH_V: owe_result(CMD_VERSION, 32'd0, 32'd0, 8'd0);
            CH_M: begin
               cur_op    = OP_M;
               base_addr = 32'd0;
               cur_phase = PH_ARG0;
            end
            CH_S: begin
               cur_op    = OP_S;
               sector_lo = 16'd0;
               sector_hi = 16'd0;
               cur_phase = PH_ARG0;
            end
            // Anything else at idle, lower-case letters included, is dropped silently.
            default: ;
         endcase
      end else if (cur_phase == PH_DATA) begin
         // Only a write reaches the data phase.
         owe_result(CMD_WRITE_BYTE, write_ptr, 32'd0, b);
         write_ptr = write_ptr + 32'd1;
         byte_left = byte_left - 32'd1;
         if ((write_ptr % PAGE_U) == 32'd0)
            owe_result(CMD_NEXT_PAGE, write_ptr, 32'd0, 8'd0);
         if (byte_left == 32'd0) begin
            owe_result(CMD_FINISH_WRITE, write_ptr, 32'd0, 8'd0);
            cur_phase = PH_IDLE;
         end
      end else begin
         // Argument bytes arrive least significant first.
         shift = 8 * (int'(cur_phase) - 1);
         case (cur_op)
            OP_M: begin
               base_addr = base_addr | ({24'd0, b} << shift);
               cur_phase = (cur_phase == PH_ARG3) ? PH_IDLE : phase_type'(cur_phase + 1);
            end
            OP_S: begin
               if (cur_phase <= PH_ARG1)
                  sector_lo = sector_lo | ({8'd0, b} << shift);
               else
                  sector_hi = sector_hi | ({8'd0, b} << (shift - 16));
               if (cur_phase == PH_ARG3) begin
                  cur_phase = PH_IDLE;
                  owe_result(CMD_ERASE_SECTORS, {16'd0, sector_lo}, {16'd0, sector_hi}, 8'd0);
               end else begin
                  cur_phase = phase_type'(cur_phase + 1);
               end
            end
            default: begin
               // Write and read share the four-byte count, top byte included.
               byte_left = byte_left | ({24'd0, b} << shift);
               if (cur_phase != PH_ARG3) begin
                  cur_phase = phase_type'(cur_phase + 1);
               end else if (cur_op == OP_W) begin
                  write_ptr = base_addr;
                  cur_phase = PH_DATA;
                  owe_result(CMD_START_WRITE, write_ptr, byte_left, 8'd0);
               end else begin
                  cur_phase = PH_IDLE;
                  owe_result(CMD_READ_RANGE, base_addr, byte_left, 8'd0);
               end
            end
         endcase
      end
      if (awaited_results.size() > first_new) begin
         r = awaited_results.pop_back();
         r.last = 1'b1;
         awaited_results.push_back(r);
      end
   endtask

   // Driver: offers host bytes on the req_ side. A request stays up until it is
   // taken; after each accepted request a random gap is drawn before the next one.
   always @(posedge clock) begin : host_driver
      logic       push_next;
      logic [7:0] byte_next;
      if (reset) begin
         req_push    <= 1'b0;
         req_rx_byte <= 8'd0;
         send_wait = 0;
      end else begin
         push_next = req_push;
         byte_next = req_rx_byte;
         if (req_push && !req_full) begin
            parse_host_byte(req_rx_byte);
            push_next = 1'b0;
            send_wait = draw_gap(send_burst);
         end
         if (!push_next) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (host_bytes.size() > 0) begin
               push_next = 1'b1;
               byte_next = host_bytes.pop_front();
            end
         end
         // A single assignment per step keeps a back-to-back request high.
         req_push    <= push_next;
         req_rx_byte <= byte_next;
      end
   end

   // Monitor: pops results with random gaps, and on request holds off for a long
   // stretch so the block's job queue fills and req_full pushes back on the driver.
   always @(posedge clock) begin : result_monitor
      parser_result_type want;
      logic              pop_next;
      if (reset) begin
         rsp_pop <= 1'b0;
         recv_wait = 0;
      end else begin
         pop_next = rsp_pop;
         if (rsp_pop && !rsp_empty) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: command %0d address %h", rsp_command, rsp_address);
               error_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_command !== want.command) begin
                  $error("command: expected %0d, actual %0d", want.command, rsp_command);
                  error_count++;
               end
               if (rsp_address !== want.address) begin
                  $error("address: expected %h, actual %h", want.address, rsp_address);
                  error_count++;
               end
               if (rsp_length !== want.length) begin
                  $error("length: expected %h, actual %h", want.length, rsp_length);
                  error_count++;
               end
               if (rsp_data !== want.data) begin
                  $error("data: expected %h, actual %h", want.data, rsp_data);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  error_count++;
               end
            end
            pop_next  = 1'b0;
            recv_wait = draw_gap(recv_burst);
         end
         if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop_next = 1'b0;
         end else if (!pop_next) begin
            if (recv_wait > 0)
               recv_wait--;
            else
               pop_next = 1'b1;
         end
         rsp_pop <= pop_next;
      end
   end

   // Watchdog: any stretch without an accepted request or result that runs too long
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("** flash_programmer_command_parser: FAILED **");
            $finish;
         end
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      host_bytes.push_back(b);
      queued_count++;
   endtask

   task automatic queue_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         queue_byte(w[8*i +: 8]);
   endtask

   // Waits until every byte is taken and every result is back, then gives requests
   // that produce nothing time to drain through the block.
   task automatic settle();
      @(negedge clock);
      while (host_bytes.size() > 0 || req_push || awaited_results.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic value);
      @(posedge clock);
      csr_we               <= 1'b1;
      csr_programming_mode <= value;
      mode_shadow = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Argument byte for random sequences: now and then a command letter, so that the
   // parser must treat letters as plain data while it collects arguments.
   function automatic logic [7:0] arg_byte();
      logic [7:0] letters[5];
      letters = '{CH_W, CH_R, CH_M, CH_S, CH_D};
      if ($urandom_range(0, 3) == 0)
         return letters[$urandom_range(0, 4)];
      return 8'($urandom);
   endfunction

   // Queues one random programming-mode sequence. The parser is idle before each one,
   // and every sequence brings it back to idle, so no write count can trap it.
   task automatic queue_random_sequence();
      logic [7:0]  singles[5];
      logic [7:0]  b;
      logic [31:0] w;
      int          kind;
      int          count;
      singles = '{CH_D, CH_Z, CH_A, CH_B, CH_V};
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         queue_byte(singles[$urandom_range(0, 4)]);
      end else if (kind < 4) begin
         // Noise at idle: any byte that would not open an argument sequence.
         b = 8'($urandom);
         while (b == CH_W || b == CH_R || b == CH_M || b == CH_S)
            b = 8'($urandom);
         queue_byte(b);
      end else if (kind < 7) begin
         w = {arg_byte(), arg_byte(), arg_byte(), arg_byte()};
         if ($urandom_range(0, 1) == 0)
            w[7:0] = 8'($urandom_range(8'hF0, 8'hFF));
         gen_base = w;
         queue_byte(CH_M);
         queue_word(w);
      end else if (kind < 10) begin
         queue_byte(CH_S);
         queue_word({arg_byte(), arg_byte(), arg_byte(), arg_byte()});
         // Sometimes a stray byte follows the erase range.
         if ($urandom_range(0, 2) == 0)
            queue_byte(8'($urandom_range(0, 8'h3F)));
      end else if (kind < 13) begin
         queue_byte(CH_R);
         queue_word({arg_byte(), arg_byte(), arg_byte(), arg_byte()});
      end else begin
         count = $urandom_range(1, 20);
         // Aim some writes so the last data byte lands right on a page boundary.
         if ($urandom_range(0, 2) == 0 && (PAGE_U - gen_base % PAGE_U) <= 32'd20)
            count = int'(PAGE_U - gen_base % PAGE_U);
         queue_byte(CH_W);
         queue_word(32'(count));
         repeat (count) queue_byte(8'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Bridge mode: field extremes and a command letter are forwarded untouched.
      write_mode(1'b0);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h55);
      queue_byte(8'hAA);
      queue_byte(CH_W);
      settle();

      // Programming mode, directed: every command and the named corner cases.
      write_mode(1'b1);
      queue_byte(8'h64);           // lower-case d is ignored
      queue_byte(CH_D);
      queue_byte(CH_Z);
      queue_byte(CH_A);
      queue_byte(CH_B);
      queue_byte(CH_V);
      // Two-byte write just below a page boundary: the second byte writes, turns the
      // page and finishes in one request.
      queue_byte(CH_M);
      queue_word(32'h0000_00FE);
      queue_byte(CH_W);
      queue_word(32'd2);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CH_S);
      queue_word(32'h0005_0001);
      queue_byte(8'h07);           // stray byte after the erase range
      queue_byte(CH_R);
      queue_word(32'd0);           // zero read count
      // Leave an address half collected, switch to bridge mode and back.
      queue_byte(CH_M);
      queue_byte(8'h12);
      queue_byte(8'h34);
      settle();
      write_mode(1'b0);
      queue_byte(8'h01);
      queue_byte(8'h02);
      settle();
      write_mode(1'b1);
      queue_byte(8'h56);
      queue_byte(8'h78);
      queue_byte(CH_R);
      queue_word(32'h8000_0003);
      settle();
      gen_base = 32'h7856_3412;

      // Random programming traffic with one long receiver hold-off at the start.
      @(negedge clock);
      hold_armed = 1'b1;
      queued_count = 0;
      while (queued_count < 40)
         queue_random_sequence();
      settle();

      // Random bridge traffic, again under back-pressure.
      write_mode(1'b0);
      @(negedge clock);
      hold_armed = 1'b1;
      repeat (10) queue_byte(8'($urandom));
      settle();

      // A zero write count never finishes, so it comes last: the pointer wraps from
      // the top of the address space into page zero.
      write_mode(1'b1);
      queue_byte(CH_M);
      queue_word(32'hFFFF_FFFE);
      queue_byte(CH_W);
      queue_word(32'd0);
      repeat (6) queue_byte(8'($urandom));
      settle();

      if (error_count == 0)
         $display("** flash_programmer_command_parser: PASSED **");
      else
         $display("** flash_programmer_command_parser: FAILED **");
      $finish;
   end

endmodule
